FILE: rtl/core/npnl_pkg.sv
`default_nettype none
// ============================================================================
// npnl_pkg: shared types and constants for nearest_point_near_line
// Field widths, queue entry layout, multiplier handshake and FSM encodings.
// ============================================================================
package npnl_pkg;

  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned THRESH_BITS = COORD_BITS - 1;
  localparam int unsigned DIFF_BITS   = COORD_BITS + 1;
  localparam int unsigned RANGE_W     = 50;

  // shared multiplier: signed MUL_W x MUL_W, unsigned CHUNK_W bits of b per cycle
  localparam int unsigned MUL_W      = 2 * COORD_BITS + 2;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned MUL_CHUNKS = (MUL_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned MUL_B_W    = MUL_CHUNKS * CHUNK_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_CHUNKS);

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_POS_X  = 2'd0;
  localparam logic [1:0] REG_POS_Y  = 2'd1;
  localparam logic [1:0] REG_POS_Z  = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
    logic signed [COORD_BITS-1:0]  coord_z;
    logic                          last;
  } npnl_in_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_BITS-1:0]  best_x;
    logic signed [COORD_BITS-1:0]  best_y;
    logic signed [COORD_BITS-1:0]  best_z;
    logic        [RANGE_W-1:0]     range_sq;
  } npnl_out_t;

  // queue entry: raw coords (direction for a start) plus point minus scanner
  typedef struct packed {
    logic                          is_point;
    logic                          last;
    logic signed [COORD_BITS-1:0]  px;
    logic signed [COORD_BITS-1:0]  py;
    logic signed [COORD_BITS-1:0]  pz;
    logic signed [DIFF_BITS-1:0]   rx;
    logic signed [DIFF_BITS-1:0]   ry;
    logic signed [DIFF_BITS-1:0]   rz;
  } npnl_entry_t;

  typedef struct packed {
    logic                      start;
    logic signed [MUL_W-1:0]   a;
    logic signed [MUL_W-1:0]   b;
  } npnl_mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [PROD_W-1:0]  p;
  } npnl_mul_rsp_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_SIGN
  } npnl_mul_st_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_WAIT,
    BK_DONE
  } npnl_bk_st_e;

  // multiply sequence for one point
  typedef enum logic [4:0] {
    STEP_CX_A,
    STEP_CX_B,
    STEP_CX_SQ,
    STEP_CY_A,
    STEP_CY_B,
    STEP_CY_SQ,
    STEP_CZ_A,
    STEP_CZ_B,
    STEP_CZ_SQ,
    STEP_RX_SQ,
    STEP_RY_SQ,
    STEP_RZ_SQ,
    STEP_DX_SQ,
    STEP_DY_SQ,
    STEP_DZ_SQ,
    STEP_T_SQ,
    STEP_RHS
  } npnl_step_e;

  function automatic logic signed [MUL_W-1:0] ext_diff(input logic signed [DIFF_BITS-1:0] v);
    ext_diff = {{(MUL_W - DIFF_BITS){v[DIFF_BITS-1]}}, v};
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_coord(input logic signed [COORD_BITS-1:0] v);
    ext_coord = {{(MUL_W - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/nearest_point_near_line.sv
`default_nettype none
// ============================================================================
// nearest_point_near_line: closest cloud point within a distance of a ray
// Configuration registers, input classifier, item queue and execution back.
// ============================================================================
// Schedule: the back dequeues a point, then runs 17 multiplies in turn on the
//   shared 50x16 digit multiplier before it takes the next item. A start
//   item needs no multiply. The input side keeps accepting until the queue fills.
// Result: a last item's result is registered once the output is free.
// Reset: control state, configuration and ray state clear at once; no sweep.
module nearest_point_near_line #(
  parameter int unsigned QUEUE_DEPTH = npnl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire npnl_pkg::npnl_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output npnl_pkg::npnl_out_t                out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [npnl_pkg::APB_AW-1:0]   paddr,
  input  wire logic [npnl_pkg::APB_DW-1:0]   pwdata,
  output logic [npnl_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  import npnl_pkg::*;

  localparam int unsigned EW = $bits(npnl_entry_t);

  logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [THRESH_BITS-1:0]       thresh_q;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;

  logic          q_push, q_pop, q_full, q_empty;
  npnl_entry_t   q_wentry, q_rentry;
  logic [EW-1:0] q_rdata;
  npnl_mul_req_t mul_req;
  npnl_mul_rsp_t mul_rsp;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      pos_z_q  <= '0;
      thresh_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POS_X:  pos_x_q  <= pwdata[COORD_BITS-1:0];
        REG_POS_Y:  pos_y_q  <= pwdata[COORD_BITS-1:0];
        REG_POS_Z:  pos_z_q  <= pwdata[COORD_BITS-1:0];
        REG_THRESH: thresh_q <= pwdata[THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_POS_X:  prdata = APB_DW'(unsigned'(pos_x_q));
      REG_POS_Y:  prdata = APB_DW'(unsigned'(pos_y_q));
      REG_POS_Z:  prdata = APB_DW'(unsigned'(pos_z_q));
      REG_THRESH: prdata = APB_DW'(thresh_q);
      default:    prdata = '0;
    endcase
  end

  npnl_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .pos_x_i    (pos_x_q),
    .pos_y_i    (pos_y_q),
    .pos_z_i    (pos_z_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wentry)
  );

  npnl_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wentry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign q_rentry = npnl_entry_t'(q_rdata);

  npnl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_rentry),
    .q_pop_o     (q_pop),
    .thresh_i    (thresh_q),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  npnl_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

endmodule
`default_nettype wire

FILE: rtl/core/npnl_fifo.sv
`default_nettype none
// ============================================================================
// npnl_fifo: small register FIFO
// Decouples the classifying front from the arithmetic back.
// ============================================================================
module npnl_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("fifo count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("fifo push while full");

endmodule
`default_nettype wire

FILE: rtl/core/npnl_front.sv
`default_nettype none
// ============================================================================
// npnl_front: input accept and classify
// Tags start or point and forms the point offset from the scanner.
// ============================================================================
module npnl_front (
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire npnl_pkg::npnl_in_t                     in_data_i,
  input  wire logic signed [npnl_pkg::COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [npnl_pkg::COORD_BITS-1:0] pos_y_i,
  input  wire logic signed [npnl_pkg::COORD_BITS-1:0] pos_z_i,
  input  wire logic                                   q_full_i,
  output logic                                        q_push_o,
  output npnl_pkg::npnl_entry_t                       q_entry_o
);
  import npnl_pkg::*;

  function automatic logic signed [DIFF_BITS-1:0] offset(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] o
  );
    offset = {p[COORD_BITS-1], p} - {o[COORD_BITS-1], o};
  endfunction

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_entry_o.is_point = (in_data_i.cmd == CMD_POINT);
    q_entry_o.last     = in_data_i.last;
    q_entry_o.px       = in_data_i.coord_x;
    q_entry_o.py       = in_data_i.coord_y;
    q_entry_o.pz       = in_data_i.coord_z;
    q_entry_o.rx       = offset(in_data_i.coord_x, pos_x_i);
    q_entry_o.ry       = offset(in_data_i.coord_y, pos_y_i);
    q_entry_o.rz       = offset(in_data_i.coord_z, pos_z_i);
  end

endmodule
`default_nettype wire

FILE: rtl/core/npnl_mul.sv
`default_nettype none
// ============================================================================
// npnl_mul: shared iterative signed multiplier
// Magnitude times magnitude, one CHUNK_W-bit digit of b per cycle, sign last.
// ============================================================================
module npnl_mul (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire npnl_pkg::npnl_mul_req_t req_i,
  output npnl_pkg::npnl_mul_rsp_t      rsp_o
);
  import npnl_pkg::*;

  npnl_mul_st_e            st_q, st_d;
  logic [MUL_CNT_W-1:0]    cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [MUL_W-1:0]        am_q, am_d;
  logic [MUL_W-1:0]        hi_q, hi_d;
  logic [MUL_B_W-1:0]      lo_q, lo_d;
  logic                    neg_q, neg_d;
  logic signed [PROD_W-1:0] p_q, p_d;

  logic [MUL_W-1:0]         a_mag, b_mag;
  logic [MUL_W+CHUNK_W-1:0] part;
  logic [MUL_W+MUL_B_W-1:0] full;

  assign a_mag = req_i.a[MUL_W-1] ? (~req_i.a + MUL_W'(1)) : req_i.a;
  assign b_mag = req_i.b[MUL_W-1] ? (~req_i.b + MUL_W'(1)) : req_i.b;
  assign part  = (MUL_W+CHUNK_W)'(hi_q)
               + (MUL_W+CHUNK_W)'(am_q) * (MUL_W+CHUNK_W)'(lo_q[CHUNK_W-1:0]);
  assign full  = {hi_q, lo_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      MUL_IDLE: if (req_i.start) st_d = MUL_RUN;
      MUL_RUN:  if (cnt_q == MUL_CNT_W'(MUL_CHUNKS - 1)) st_d = MUL_SIGN;
      MUL_SIGN: st_d = MUL_IDLE;
      default:  st_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    am_d   = am_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    neg_d  = neg_q;
    p_d    = p_q;
    unique case (st_q)
      MUL_IDLE: begin
        if (req_i.start) begin
          am_d  = a_mag;
          hi_d  = '0;
          lo_d  = MUL_B_W'(b_mag);
          neg_d = req_i.a[MUL_W-1] ^ req_i.b[MUL_W-1];
          cnt_d = '0;
        end
      end
      MUL_RUN: begin
        // shift the finished low digit down into lo
        hi_d  = part[MUL_W+CHUNK_W-1:CHUNK_W];
        lo_d  = {part[CHUNK_W-1:0], lo_q[MUL_B_W-1:CHUNK_W]};
        cnt_d = cnt_q + MUL_CNT_W'(1);
      end
      MUL_SIGN: begin
        p_d    = neg_q ? -signed'(full[PROD_W-1:0]) : signed'(full[PROD_W-1:0]);
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MUL_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    am_q  <= am_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    neg_q <= neg_d;
    p_q   <= p_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = p_q;

endmodule
`default_nettype wire

FILE: rtl/core/npnl_back.sv
`default_nettype none
// ============================================================================
// npnl_back: per-item execution and result register
// Runs the line-distance test and nearest-point search on the shared multiplier.
// ============================================================================
module npnl_back (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   q_empty_i,
  input  wire npnl_pkg::npnl_entry_t                  q_entry_i,
  output logic                                        q_pop_o,
  input  wire logic [npnl_pkg::THRESH_BITS-1:0]       thresh_i,
  output npnl_pkg::npnl_mul_req_t                     mul_req_o,
  input  wire npnl_pkg::npnl_mul_rsp_t                mul_rsp_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output npnl_pkg::npnl_out_t                         out_data_o
);
  import npnl_pkg::*;

  localparam int unsigned XW = (MUL_W > RANGE_W) ? MUL_W : RANGE_W;
  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

  npnl_bk_st_e              state_q, state_d;
  npnl_step_e               step_q, step_d;
  logic                     found_q, found_d;
  logic signed [COORD_BITS-1:0] dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic signed [COORD_BITS-1:0] bpx_q, bpy_q, bpz_q, bpx_d, bpy_d, bpz_d;
  logic                     out_valid_q, out_valid_d;

  npnl_entry_t              ent_q, ent_d;
  logic signed [MUL_W-1:0]  c_q, c_d;
  logic [MUL_W-1:0]         tt_q, tt_d;
  logic [MUL_W-1:0]         rng_q, rng_d;
  logic [PROD_W-1:0]        lhs_q, lhs_d;
  logic [MUL_W-1:0]         best_range_q, best_range_d;
  npnl_out_t                out_q, out_d;

  logic                     out_free, out_load;
  logic [MUL_W-1:0]         p_lo;
  logic [PROD_W-1:0]        p_u;
  logic                     qual, closer;
  logic [XW-1:0]            range_x;
  logic [RANGE_W-1:0]       range_sat;

  assign out_free  = !out_valid_q || out_ready_i;
  assign p_lo      = mul_rsp_i.p[MUL_W-1:0];
  assign p_u       = mul_rsp_i.p;
  assign qual      = lhs_q < p_u;
  assign closer    = rng_q < best_range_q;
  assign range_x   = XW'(best_range_q);
  assign range_sat = (range_x > XW'(RANGE_MAX)) ? RANGE_MAX : range_x[RANGE_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_entry_i.is_point) state_d = BK_ISSUE;
          else if (q_entry_i.last) state_d = BK_DONE;
        end
      end
      BK_ISSUE: state_d = BK_WAIT;
      BK_WAIT: begin
        if (mul_rsp_i.done) begin
          if (step_q != STEP_RHS) state_d = BK_ISSUE;
          else if (ent_q.last) state_d = BK_DONE;
          else state_d = BK_IDLE;
        end
      end
      BK_DONE: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // handshake outputs and multiplier operands
  always_comb begin
    q_pop_o         = (state_q == BK_IDLE) && !q_empty_i;
    out_load        = (state_q == BK_DONE) && out_free;
    mul_req_o.start = (state_q == BK_ISSUE);
    mul_req_o.a     = '0;
    mul_req_o.b     = '0;
    unique case (step_q)
      STEP_CX_A: begin mul_req_o.a = ext_diff(ent_q.ry); mul_req_o.b = ext_coord(dz_q); end
      STEP_CX_B: begin mul_req_o.a = ext_diff(ent_q.rz); mul_req_o.b = ext_coord(dy_q); end
      STEP_CY_A: begin mul_req_o.a = ext_diff(ent_q.rz); mul_req_o.b = ext_coord(dx_q); end
      STEP_CY_B: begin mul_req_o.a = ext_diff(ent_q.rx); mul_req_o.b = ext_coord(dz_q); end
      STEP_CZ_A: begin mul_req_o.a = ext_diff(ent_q.rx); mul_req_o.b = ext_coord(dy_q); end
      STEP_CZ_B: begin mul_req_o.a = ext_diff(ent_q.ry); mul_req_o.b = ext_coord(dx_q); end
      STEP_CX_SQ, STEP_CY_SQ, STEP_CZ_SQ: begin
        mul_req_o.a = c_q;
        mul_req_o.b = c_q;
      end
      STEP_RX_SQ: begin mul_req_o.a = ext_diff(ent_q.rx); mul_req_o.b = ext_diff(ent_q.rx); end
      STEP_RY_SQ: begin mul_req_o.a = ext_diff(ent_q.ry); mul_req_o.b = ext_diff(ent_q.ry); end
      STEP_RZ_SQ: begin mul_req_o.a = ext_diff(ent_q.rz); mul_req_o.b = ext_diff(ent_q.rz); end
      STEP_DX_SQ: begin mul_req_o.a = ext_coord(dx_q); mul_req_o.b = ext_coord(dx_q); end
      STEP_DY_SQ: begin mul_req_o.a = ext_coord(dy_q); mul_req_o.b = ext_coord(dy_q); end
      STEP_DZ_SQ: begin mul_req_o.a = ext_coord(dz_q); mul_req_o.b = ext_coord(dz_q); end
      STEP_T_SQ: begin
        mul_req_o.a = signed'(MUL_W'(thresh_i));
        mul_req_o.b = signed'(MUL_W'(thresh_i));
      end
      STEP_RHS: begin
        mul_req_o.a = signed'(tt_q);
        mul_req_o.b = c_q;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    step_d       = step_q;
    found_d      = found_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    dz_d         = dz_q;
    bpx_d        = bpx_q;
    bpy_d        = bpy_q;
    bpz_d        = bpz_q;
    ent_d        = ent_q;
    c_d          = c_q;
    tt_d         = tt_q;
    rng_d        = rng_q;
    lhs_d        = lhs_q;
    best_range_d = best_range_q;
    out_d        = out_q;
    out_valid_d  = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

    if (q_pop_o) begin
      ent_d  = q_entry_i;
      step_d = STEP_CX_A;
      if (!q_entry_i.is_point) begin
        // new ray: load direction, drop the search
        dx_d    = q_entry_i.px;
        dy_d    = q_entry_i.py;
        dz_d    = q_entry_i.pz;
        found_d = 1'b0;
        bpx_d   = '0;
        bpy_d   = '0;
        bpz_d   = '0;
      end
    end

    if ((state_q == BK_WAIT) && mul_rsp_i.done) begin
      step_d = npnl_step_e'(5'(step_q) + 5'd1);
      case (step_q)
        STEP_CX_A, STEP_CY_A, STEP_CZ_A, STEP_DX_SQ: c_d = signed'(p_lo);
        STEP_CX_B, STEP_CY_B, STEP_CZ_B:             c_d = c_q - signed'(p_lo);
        STEP_DY_SQ, STEP_DZ_SQ:                      c_d = c_q + signed'(p_lo);
        STEP_CX_SQ:                                  lhs_d = p_u;
        STEP_CY_SQ, STEP_CZ_SQ:                      lhs_d = lhs_q + p_u;
        STEP_RX_SQ:                                  rng_d = p_lo;
        STEP_RY_SQ, STEP_RZ_SQ:                      rng_d = rng_q + p_lo;
        STEP_T_SQ:                                   tt_d = p_lo;
        STEP_RHS: begin
          step_d = STEP_CX_A;
          if (qual && (!found_q || closer)) begin
            found_d      = 1'b1;
            best_range_d = rng_q;
            bpx_d        = ent_q.px;
            bpy_d        = ent_q.py;
            bpz_d        = ent_q.pz;
          end
        end
        default: ;
      endcase
    end

    if (out_load) begin
      out_d.hit      = found_q;
      out_d.best_x   = found_q ? bpx_q : '0;
      out_d.best_y   = found_q ? bpy_q : '0;
      out_d.best_z   = found_q ? bpz_q : '0;
      out_d.range_sq = found_q ? range_sat : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= STEP_CX_A;
      found_q     <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
      dz_q        <= '0;
      bpx_q       <= '0;
      bpy_q       <= '0;
      bpz_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      found_q     <= found_d;
      dx_q        <= dx_d;
      dy_q        <= dy_d;
      dz_q        <= dz_d;
      bpx_q       <= bpx_d;
      bpy_q       <= bpy_d;
      bpz_q       <= bpz_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q        <= ent_d;
    c_q          <= c_d;
    tt_q         <= tt_d;
    rng_q        <= rng_d;
    lhs_q        <= lhs_d;
    best_range_q <= best_range_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> state_q == BK_WAIT)
    else $error("multiplier result outside wait state");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DONE) && out_free |=> out_valid_q && (state_q == BK_IDLE))
    else $error("result not posted from done state");

  a_clear_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (bpx_q == '0) && (bpy_q == '0) && (bpz_q == '0))
    else $error("best point set without a hit");

endmodule
`default_nettype wire
